[rtl/crcbe_pkg.sv]
package crcbe_pkg;

    localparam int CRC_MAX_W   = 64;
    localparam int WIDTH_REG_W = 7;
    localparam int CFG_INDEX_W = 3;
    localparam int DATA_W      = 8;

    typedef logic [CRC_MAX_W-1:0]   crc_word_t;
    typedef logic [WIDTH_REG_W-1:0] width_t;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    // Register indexes of the configuration channel.
    localparam cfg_index_t REG_CRC_WIDTH      = 3'd0;
    localparam cfg_index_t REG_POLYNOMIAL     = 3'd1;
    localparam cfg_index_t REG_INITIAL_VALUE  = 3'd2;
    localparam cfg_index_t REG_FINAL_XOR      = 3'd3;
    localparam cfg_index_t REG_REFLECT_INPUT  = 3'd4;
    localparam cfg_index_t REG_REFLECT_OUTPUT = 3'd5;

    // Reset values: the common 32-bit Ethernet CRC.
    localparam width_t    RST_CRC_WIDTH      = 7'd32;
    localparam crc_word_t RST_POLYNOMIAL     = 64'h0000_0000_04C1_1DB7;
    localparam crc_word_t RST_INITIAL_VALUE  = 64'h0000_0000_FFFF_FFFF;
    localparam crc_word_t RST_FINAL_XOR      = 64'h0000_0000_FFFF_FFFF;

    localparam width_t MIN_WIDTH = 7'd3;
    localparam width_t MAX_WIDTH = 7'd64;

    // Datapath controls derived from the configuration registers.
    typedef struct packed {
        crc_word_t poly_top;
        crc_word_t final_xor;
        crc_word_t width_mask;
        width_t    shift;
        logic      reflect_in;
        logic      reflect_out;
    } crc_ctrl_t;

    function automatic width_t clamp_width(input width_t w);
        width_t r;
        r = w;
        if (w < MIN_WIDTH) begin
            r = MIN_WIDTH;
        end else if (w > MAX_WIDTH) begin
            r = MAX_WIDTH;
        end
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] reverse_byte(input logic [DATA_W-1:0] v);
        logic [DATA_W-1:0] r;
        for (int i = 0; i < DATA_W; i++) begin
            r[i] = v[DATA_W-1-i];
        end
        return r;
    endfunction

    function automatic crc_word_t reverse_word(input crc_word_t v);
        crc_word_t r;
        for (int i = 0; i < CRC_MAX_W; i++) begin
            r[i] = v[CRC_MAX_W-1-i];
        end
        return r;
    endfunction

endpackage

[rtl/crcbe_datapath.sv]
module crcbe_datapath (
    input  crcbe_pkg::crc_word_t          remainder,
    input  logic [crcbe_pkg::DATA_W-1:0]  data_byte,
    input  logic                          byte_present,
    input  crcbe_pkg::crc_ctrl_t          ctrl,
    output crcbe_pkg::crc_word_t          remainder_out,
    output crcbe_pkg::crc_word_t          crc_result
);
    import crcbe_pkg::*;

    logic [DATA_W-1:0] byte_in;
    crc_word_t         absorbed;
    crc_word_t         aligned;

    // Eight polynomial steps over the top-aligned remainder, unrolled.
    always_comb begin
        crc_word_t r;
        byte_in = ctrl.reflect_in ? reverse_byte(data_byte) : data_byte;
        r = remainder ^ {byte_in, {(CRC_MAX_W-DATA_W){1'b0}}};
        for (int k = 0; k < DATA_W; k++) begin
            if (r[CRC_MAX_W-1]) begin
                r = {r[CRC_MAX_W-2:0], 1'b0} ^ ctrl.poly_top;
            end else begin
                r = {r[CRC_MAX_W-2:0], 1'b0};
            end
        end
        absorbed = r;
    end

    assign remainder_out = byte_present ? absorbed : remainder;

    // The bits below the CRC are always zero, so a full-word reversal of the
    // top-aligned value is already the reflection over the width.
    assign aligned    = ctrl.reflect_out ? reverse_word(remainder_out)
                                         : (remainder_out >> ctrl.shift);
    assign crc_result = (aligned ^ ctrl.final_xor) & ctrl.width_mask;

endmodule

[rtl/configurable_crc_byte_engine_unit.sv]
// Configurable byte-wise CRC engine, MSB-first, any width from 3 to 64.
//
// Input channel (s_*): one request carries one message byte in s_tdata, a
// byte-present flag in s_tuser and the end-of-message mark in s_tlast. A
// request with s_tuser low and s_tlast high ends an empty message.
// Result channel (m_*): one request per finished message, the CRC in m_tdata,
// right-aligned and masked to the configured width.
// Configuration channel (cfg_*): writes one register per request; cfg_ready
// is always high. Every write to a listed register reloads the running
// remainder, so it is meant to be issued between messages while the engine
// is idle. A write to an index beyond the list changes nothing.
//
// Throughput is one input request per cycle while the skid register is
// not full; the eight polynomial steps of a byte are one unrolled xor
// network on the remainder register, which sets the cycle time. The CRC
// goes to the output register, or to the skid register when it is stalled.
// When the receiver stalls, the output register and one skid register hold
// up to two results; s_tready drops only while the skid register is full.
// After reset the registers hold the 32-bit Ethernet CRC setup and the
// remainder holds its initial value; no result is pending.
module configurable_crc_byte_engine_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Input channel.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [7:0] data_byte
    input  logic [0:0]                       s_tuser,   // [0] byte_present
    input  logic                             s_tlast,   // message_end
    // Result channel.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [63:0]                      m_tdata,   // [63:0] crc_result
    // Configuration channel.
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [crcbe_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [63:0]                      cfg_data
);
    import crcbe_pkg::*;

    // Configuration registers.
    width_t    crc_width_reg,   crc_width_next;
    crc_word_t poly_reg,        poly_next;
    crc_word_t init_reg,        init_next;
    crc_word_t final_xor_reg,   final_xor_next;
    logic      refl_in_reg,     refl_in_next;
    logic      refl_out_reg,    refl_out_next;

    // Running remainder, top-aligned.
    crc_word_t remainder_reg,   remainder_next;

    // Output register plus skid register.
    logic      out_valid_reg,   out_valid_next;
    crc_word_t out_data_reg,    out_data_next;
    logic      skid_valid_reg,  skid_valid_next;
    crc_word_t skid_data_reg,   skid_data_next;

    logic      s_accept;
    logic      cfg_accept;
    logic      cfg_hit;
    logic      res_valid;
    width_t    eff_width;
    width_t    eff_width_new;
    crc_word_t init_top;
    crc_word_t init_top_new;
    crc_word_t step_remainder;
    crc_word_t step_result;
    crc_ctrl_t ctrl;

    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign s_tready   = !skid_valid_reg;
    assign s_accept   = s_tvalid && s_tready;
    assign res_valid  = s_accept && s_tlast;

    // Controls for the datapath, all derived from the current registers.
    assign eff_width       = clamp_width(crc_width_reg);
    assign ctrl.shift      = MAX_WIDTH - eff_width;
    assign ctrl.poly_top   = poly_reg << ctrl.shift;
    assign ctrl.final_xor  = final_xor_reg;
    assign ctrl.width_mask = ~({CRC_MAX_W{1'b1}} << eff_width);
    assign ctrl.reflect_in = refl_in_reg;
    assign ctrl.reflect_out = refl_out_reg;
    assign init_top        = init_reg << ctrl.shift;

    crcbe_datapath u_datapath (
        .remainder     (remainder_reg),
        .data_byte     (s_tdata),
        .byte_present  (s_tuser[0]),
        .ctrl          (ctrl),
        .remainder_out (step_remainder),
        .crc_result    (step_result)
    );

    // Register writes. An index beyond the register list changes nothing.
    always_comb begin
        crc_width_next = crc_width_reg;
        poly_next      = poly_reg;
        init_next      = init_reg;
        final_xor_next = final_xor_reg;
        refl_in_next   = refl_in_reg;
        refl_out_next  = refl_out_reg;
        cfg_hit        = 1'b0;
        if (cfg_accept) begin
            unique case (cfg_index)
                REG_CRC_WIDTH: begin
                    crc_width_next = cfg_data[WIDTH_REG_W-1:0];
                    cfg_hit        = 1'b1;
                end
                REG_POLYNOMIAL: begin
                    poly_next = cfg_data;
                    cfg_hit   = 1'b1;
                end
                REG_INITIAL_VALUE: begin
                    init_next = cfg_data;
                    cfg_hit   = 1'b1;
                end
                REG_FINAL_XOR: begin
                    final_xor_next = cfg_data;
                    cfg_hit        = 1'b1;
                end
                REG_REFLECT_INPUT: begin
                    refl_in_next = cfg_data[0];
                    cfg_hit      = 1'b1;
                end
                REG_REFLECT_OUTPUT: begin
                    refl_out_next = cfg_data[0];
                    cfg_hit       = 1'b1;
                end
                default: ;
            endcase
        end
    end

    // The reload after a write uses the values that the write leaves behind.
    assign eff_width_new = clamp_width(crc_width_next);
    assign init_top_new  = init_next << (MAX_WIDTH - eff_width_new);

    // Remainder update. A write to a listed register reloads it; a write to an
    // index beyond the list leaves the message in progress untouched.
    always_comb begin
        remainder_next = remainder_reg;
        if (cfg_hit) begin
            remainder_next = init_top_new;
        end else if (s_accept) begin
            remainder_next = s_tlast ? init_top : step_remainder;
        end
    end

    // Output register and skid register. A new result goes straight to the
    // output register when it is free or being taken, otherwise to the skid.
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (m_tready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next  = res_valid;
                out_data_next   = step_result;
            end
        end else if (res_valid) begin
            skid_valid_next = 1'b1;
            skid_data_next  = step_result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_width_reg  <= RST_CRC_WIDTH;
            poly_reg       <= RST_POLYNOMIAL;
            init_reg       <= RST_INITIAL_VALUE;
            final_xor_reg  <= RST_FINAL_XOR;
            refl_in_reg    <= 1'b1;
            refl_out_reg   <= 1'b1;
            remainder_reg  <= RST_INITIAL_VALUE << (MAX_WIDTH - RST_CRC_WIDTH);
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            crc_width_reg  <= crc_width_next;
            poly_reg       <= poly_next;
            init_reg       <= init_next;
            final_xor_reg  <= final_xor_next;
            refl_in_reg    <= refl_in_next;
            refl_out_reg   <= refl_out_next;
            remainder_reg  <= remainder_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // The skid register is filled only behind a stalled output register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a result while the output register is empty");

    // Bits below the CRC field of the remainder stay zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (remainder_reg & ~({CRC_MAX_W{1'b1}} << ctrl.shift)) == '0)
        else $error("remainder has bits set below the CRC field");

    // The end of a message reloads the initial value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tlast && !cfg_accept) |=> (remainder_reg == init_top))
        else $error("remainder not reloaded after message end");

    // A presented result never has bits above the configured width.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata & ~ctrl.width_mask) == '0))
        else $error("result has bits above the CRC width");

endmodule
